### rtl/srgblab_pkg.sv
// shared types, constants and rom builder functions for the srgb to cielab unit
`default_nettype none

package srgblab_pkg;

	// field widths
	localparam int CHAN_W     = 8;
	localparam int GAMMA_DEPTH = 256;
	localparam int LIN_W      = 16;
	localparam int COEF_W     = 16;
	localparam int TERM_W     = LIN_W + COEF_W;
	// row sums of the matrix stay below 2^17, linear values below 2^16
	localparam int XYZ_W      = 33;
	localparam int F_W        = 16;
	localparam int L_W        = 15;
	localparam int AB_W       = 16;

	localparam int F_TABLE_DEPTH_DEF = 1024;

	// srgb to xyz matrix, unsigned q0.16, row = x y z, column = r g b
	localparam logic [0:2][0:2][COEF_W-1:0] MAT_Q16 = '{
		'{16'd27031, 16'd23434, 16'd11825},
		'{16'd13938, 16'd46868, 16'd4730},
		'{16'd1267,  16'd7811,  16'd62279}
	};

	// channel full scale (x1e5) and reference white (x1e6); every full scale
	// lies between 2^16 and 2^17
	localparam logic [0:2][16:0] MAX_E5   = '{17'd95047, 17'd100000, 17'd108883};
	localparam logic [0:2][20:0] WHITE_E6 = '{21'd950456, 21'd1000000, 21'd1088754};

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic        [L_W-1:0]  lightness;
		logic signed [AB_W-1:0] green_red;
		logic signed [AB_W-1:0] blue_yellow;
	} lab_t;

	// fifth power in q0.30, truncated after every product
	function automatic logic [63:0] pow5_q30(input logic [63:0] r);
		logic [63:0] p;
		p = r;
		for (int n = 0; n < 4; n++) begin
			p = (p * r) >> 30;
		end
		return p;
	endfunction

	// cube in q0.30, truncated after every product
	function automatic logic [63:0] cube_q30(input logic [63:0] r);
		return (((r * r) >> 30) * r) >> 30;
	endfunction

	// gamma table entry: srgb byte to linear q0.16
	function automatic logic [F_W-1:0] gamma_entry(input int unsigned v);
		logic [63:0] vv;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] r;
		logic [63:0] c;
		logic [63:0] e;
		vv = 64'(v);
		t = 64'd0;
		s = 64'd0;
		r = 64'd0;
		if (vv * 64'd100000 <= 64'd4045 * 64'd255) begin
			e = (vv * 64'd100 * 64'd65536 + 64'd164730) / 64'd329460;
		end else begin
			t = ((64'd1000 * vv + 64'd14025) << 30) / 64'd269025;
			s = (t * t) >> 30;
			for (int b = 30; b >= 0; b--) begin
				c = r | (64'd1 << b);
				if (c <= (64'd1 << 30)) begin
					if (pow5_q30(c) <= s) begin
						r = c;
					end
				end
			end
			e = (s * r + (64'd1 << 43)) >> 44;
		end
		return (e > 64'd65535) ? 16'hFFFF : e[F_W-1:0];
	endfunction

	// f(t) table entry in q1.15 for channel k, entry i of depth entries;
	// quotients are found by bit search against products
	function automatic logic [F_W-1:0] f_entry(input int unsigned k, input int unsigned i,
			input int unsigned depth);
		logic [63:0]  mx;
		logic [63:0]  wt;
		logic [63:0]  den;
		logic [63:0]  num;
		logic [63:0]  r;
		logic [63:0]  c;
		logic [63:0]  e;
		logic [127:0] lim;
		mx  = 64'(MAX_E5[k]);
		wt  = 64'(WHITE_E6[k]);
		den = 64'(depth) * wt;
		num = mx * 64'd10 * 64'(i);
		r   = 64'd0;
		e   = 64'd0;
		if (num * 64'd1000000 > 64'd8856 * den) begin
			// cube root: largest r with cube(r) <= num * 2^30 / den
			lim = 128'(num) << 30;
			for (int b = 30; b >= 0; b--) begin
				c = r | (64'd1 << b);
				if (128'(cube_q30(c)) * 128'(den) <= lim) begin
					r = c;
				end
			end
			e = (r + (64'd1 << 14)) >> 15;
		end else begin
			// linear segment, rounded half up
			lim = 128'(64'd9033 * num + 64'd160 * den) * 128'd32768 + 128'(64'd580 * den);
			for (int b = 16; b >= 0; b--) begin
				c = e | (64'd1 << b);
				if (128'(c) * 128'(64'd1160 * den) <= lim) begin
					e = c;
				end
			end
		end
		return (e > 64'd65535) ? 16'hFFFF : e[F_W-1:0];
	endfunction

endpackage

`default_nettype wire

### rtl/srgb_to_cielab_pixel_unit.sv
// srgb to cielab pixel converter, nine stage pipeline
// a transaction accepted at a clock edge is captured in s1 at that edge and moves through
//   stages s2 to s9 before it shows on lab with done high
// throughput: one pixel per clock, busy stays low since no stage ever waits
// the result is shown for one cycle only; the receiver takes it as it comes
// reset clears the stage valid bits; the gamma and f(t) tables are constant logic
`default_nettype none

module srgb_to_cielab_pixel_unit #(
	parameter int F_TABLE_DEPTH = srgblab_pkg::F_TABLE_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire srgblab_pkg::pixel_t pixel,
	output logic                     done,
	output srgblab_pkg::lab_t        lab
);

	localparam int CHAN_W  = srgblab_pkg::CHAN_W;
	localparam int LIN_W   = srgblab_pkg::LIN_W;
	localparam int TERM_W  = srgblab_pkg::TERM_W;
	localparam int XYZ_W   = srgblab_pkg::XYZ_W;
	localparam int F_W     = srgblab_pkg::F_W;
	localparam int L_W     = srgblab_pkg::L_W;
	localparam int AB_W    = srgblab_pkg::AB_W;

	// index scaling: idx = round(xyz * (depth-1) * 200000 / (max * 2^33))
	localparam int IDX_W = $clog2(F_TABLE_DEPTH);
	localparam logic [63:0] IDX_SCALE = 64'(F_TABLE_DEPTH - 1) * 64'd200000;
	localparam int SCALE_W  = $clog2(IDX_SCALE + 64'd1);
	localparam int SCALED_W = XYZ_W + SCALE_W;
	localparam int HALF_SHIFT = 32;
	// quotient of the scaled sum by 2^33, then by the channel full scale
	localparam int P_W = SCALED_W - HALF_SHIFT;
	// reciprocal shift leaves the product exact for every full scale below 2^17
	localparam int R_S = P_W + 17;
	localparam int R_W = R_S - 16;
	localparam int Q_W = P_W - 16;
	localparam logic [Q_W-1:0] IDX_LAST = Q_W'(F_TABLE_DEPTH - 1);

	// lab output scaling
	localparam logic signed [23:0] L_GAIN    = 24'sd116;
	localparam logic signed [23:0] L_OFFSET  = 24'sd524288;
	localparam logic signed [25:0] A_GAIN    = 26'sd500;
	localparam logic signed [25:0] B_GAIN    = 26'sd200;
	localparam logic signed [16:0] L_MAX     = 17'sd25600;
	localparam logic signed [18:0] AB_MAX    = 19'sd32767;
	localparam logic signed [18:0] AB_MIN    = -19'sd32768;

	// constant tables, evaluated at elaboration
	logic [F_W-1:0] gamma_rom [srgblab_pkg::GAMMA_DEPTH];
	logic [F_W-1:0] f_rom     [3][F_TABLE_DEPTH];

	for (genvar v = 0; v < srgblab_pkg::GAMMA_DEPTH; v++) begin : g_gamma
		localparam logic [F_W-1:0] G_VAL = srgblab_pkg::gamma_entry(v);
		assign gamma_rom[v] = G_VAL;
	end

	for (genvar k = 0; k < 3; k++) begin : g_fk
		for (genvar i = 0; i < F_TABLE_DEPTH; i++) begin : g_fi
			localparam logic [F_W-1:0] F_VAL = srgblab_pkg::f_entry(k, i, F_TABLE_DEPTH);
			assign f_rom[k][i] = F_VAL;
		end
	end

	// pipeline valid bits, one per stage
	logic [8:0] valid_s;

	// stage payloads
	logic [LIN_W-1:0]    lin_s1    [3];
	logic [TERM_W-1:0]   term_s2   [3][3];
	logic [XYZ_W-1:0]    xyz_s3    [3];
	logic [SCALED_W-1:0] scaled_s4 [3];
	logic [P_W-1:0]      p_s5      [3];
	logic [Q_W-1:0]      q_s6      [3];
	logic [F_W-1:0]      f_s7      [3];
	logic signed [23:0]  l_pre_s8;
	logic signed [25:0]  a_pre_s8;
	logic signed [25:0]  b_pre_s8;
	srgblab_pkg::lab_t   lab_s9;

	logic [CHAN_W-1:0]   chan_byte [3];
	logic                accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	assign chan_byte[0] = pixel.red;
	assign chan_byte[1] = pixel.green;
	assign chan_byte[2] = pixel.blue;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[7:0], accept};
		end
	end

	// s1: gamma lookup, s2: matrix terms, s3: row sums
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			lin_s1[c] <= gamma_rom[chan_byte[c]];
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				term_s2[r][c] <= TERM_W'(lin_s1[c]) * TERM_W'(srgblab_pkg::MAT_Q16[r][c]);
			end
			xyz_s3[r] <= XYZ_W'(term_s2[r][0]) + XYZ_W'(term_s2[r][1])
				+ XYZ_W'(term_s2[r][2]);
		end
	end

	// per channel index computation and f(t) lookup
	for (genvar k = 0; k < 3; k++) begin : g_ch
		localparam logic [16:0] MAXV = srgblab_pkg::MAX_E5[k];
		localparam logic [63:0] RECIP = ((64'd1 << R_S) + 64'(MAXV) - 64'd1) / 64'(MAXV);
		localparam logic [SCALED_W:0] ROUND_ADD = (SCALED_W+1)'(64'(MAXV) << HALF_SHIFT);

		logic [SCALED_W:0]    rounded;
		logic [P_W+R_W-1:0]   recip_prod;
		logic [IDX_W-1:0]     idx;

		assign rounded    = {1'b0, scaled_s4[k]} + ROUND_ADD;
		assign recip_prod = (P_W+R_W)'(p_s5[k]) * (P_W+R_W)'(RECIP);
		// index saturates at the last table entry
		assign idx = (q_s6[k] > IDX_LAST) ? IDX_LAST[IDX_W-1:0] : q_s6[k][IDX_W-1:0];

		always_ff @(posedge clk) begin
			scaled_s4[k] <= SCALED_W'(xyz_s3[k]) * SCALED_W'(IDX_SCALE);
			p_s5[k]      <= rounded[SCALED_W:HALF_SHIFT+1];
			q_s6[k]      <= recip_prod[P_W+R_W-1:R_S];
			f_s7[k]      <= f_rom[k][idx];
		end
	end

	// s8: L, a, b in q.15 before rounding
	logic signed [16:0] diff_xy;
	logic signed [16:0] diff_yz;
	logic signed [23:0] l_pre;
	logic signed [25:0] a_pre;
	logic signed [25:0] b_pre;

	always_comb begin
		diff_xy = $signed({1'b0, f_s7[0]}) - $signed({1'b0, f_s7[1]});
		diff_yz = $signed({1'b0, f_s7[1]}) - $signed({1'b0, f_s7[2]});
		l_pre   = $signed({8'd0, f_s7[1]}) * L_GAIN - L_OFFSET;
		a_pre   = $signed({{9{diff_xy[16]}}, diff_xy}) * A_GAIN;
		b_pre   = $signed({{9{diff_yz[16]}}, diff_yz}) * B_GAIN;
	end

	always_ff @(posedge clk) begin
		l_pre_s8 <= l_pre;
		a_pre_s8 <= a_pre;
		b_pre_s8 <= b_pre;
	end

	// s9: q.15 to q.8 rounding half up (floor of x + 64), then clamp
	logic signed [23:0] l_bias;
	logic signed [25:0] a_bias;
	logic signed [25:0] b_bias;
	logic signed [16:0] l_rnd;
	logic signed [18:0] a_rnd;
	logic signed [18:0] b_rnd;
	srgblab_pkg::lab_t  lab_next;

	always_comb begin
		l_bias = l_pre_s8 + 24'sd64;
		a_bias = a_pre_s8 + 26'sd64;
		b_bias = b_pre_s8 + 26'sd64;
		l_rnd  = $signed(l_bias[23:7]);
		a_rnd  = $signed(a_bias[25:7]);
		b_rnd  = $signed(b_bias[25:7]);

		if (l_rnd < 17'sd0) begin
			lab_next.lightness = '0;
		end else if (l_rnd > L_MAX) begin
			lab_next.lightness = L_MAX[L_W-1:0];
		end else begin
			lab_next.lightness = l_rnd[L_W-1:0];
		end

		if (a_rnd > AB_MAX) begin
			lab_next.green_red = AB_MAX[AB_W-1:0];
		end else if (a_rnd < AB_MIN) begin
			lab_next.green_red = AB_MIN[AB_W-1:0];
		end else begin
			lab_next.green_red = a_rnd[AB_W-1:0];
		end

		if (b_rnd > AB_MAX) begin
			lab_next.blue_yellow = AB_MAX[AB_W-1:0];
		end else if (b_rnd < AB_MIN) begin
			lab_next.blue_yellow = AB_MIN[AB_W-1:0];
		end else begin
			lab_next.blue_yellow = b_rnd[AB_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		lab_s9 <= lab_next;
	end

	// result strobe and payload
	assign done = valid_s[8];
	assign lab  = lab_s9;

endmodule

`default_nettype wire

### sim/lab_checker.sv
// checker for the srgb to cielab unit: predicts each pixel's lab value and compares results
module lab_checker #(
	parameter int F_DEPTH = srgblab_pkg::F_TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  srgblab_pkg::pixel_t pixel,
	input  logic                done,
	input  srgblab_pkg::lab_t   lab,
	output int unsigned         fail_count,
	output int unsigned         pending,
	output int unsigned         compared
);
	import srgblab_pkg::*;

	// srgb to xyz mix, q0.16, row major
	localparam bit [0:8][15:0] MIX = {
		16'd27031, 16'd23434, 16'd11825,
		16'd13938, 16'd46868, 16'd4730,
		16'd1267,  16'd7811,  16'd62279
	};
	localparam bit [0:2][16:0] FULL_E5  = {17'd95047, 17'd100000, 17'd108883};
	localparam bit [0:2][20:0] WHITE_E6 = {21'd950456, 21'd1000000, 21'd1088754};

	typedef struct packed {
		pixel_t src;
		lab_t   lab;
	} lab_entry_t;

	bit [15:0]   linear_lut [256];
	bit [15:0]   f_lut [3][F_DEPTH];
	lab_entry_t  lab_expected [$];
	int unsigned mismatch_n = 0;
	int unsigned pending_n = 0;
	int unsigned compared_n = 0;

	assign fail_count = mismatch_n;
	assign pending    = pending_n;
	assign compared   = compared_n;

	// n-th power in q0.30, truncating after every product
	function automatic bit [63:0] q30_power(input bit [63:0] r, input int n);
		bit [63:0] p;
		p = r;
		for (int m = 1; m < n; m++) begin
			p = (p * r) >> 30;
		end
		return p;
	endfunction

	function automatic longint round_to_q8(input longint x);
		return (x + 64) >>> 7;
	endfunction

	function automatic longint limit_to(input longint x, input longint lo, input longint hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	// constant tables, rebuilt here from their exact integer definition
	initial begin
		bit [63:0] t, s, r, c, e, den, num, fn;
		for (int v = 0; v < 256; v++) begin
			if (64'(v) * 64'd100000 <= 64'd4045 * 64'd255) begin
				e = (64'(v) * 64'd6553600 + 64'd164730) / 64'd329460;
			end else begin
				t = ((64'd1000 * 64'(v) + 64'd14025) << 30) / 64'd269025;
				s = (t * t) >> 30;
				r = 64'd0;
				for (int bp = 30; bp >= 0; bp--) begin
					c = r | (64'd1 << bp);
					if (c <= (64'd1 << 30) && q30_power(c, 5) <= s) begin
						r = c;
					end
				end
				e = (s * r + (64'd1 << 43)) >> 44;
			end
			linear_lut[v] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
		end
		for (int k = 0; k < 3; k++) begin
			den = 64'(F_DEPTH) * 64'(WHITE_E6[k]);
			for (int i = 0; i < F_DEPTH; i++) begin
				num = 64'(FULL_E5[k]) * 64'd10 * 64'(i);
				if (num * 64'd1000000 > 64'd8856 * den) begin
					// cube root segment
					fn = (num << 30) / den;
					r = 64'd0;
					for (int bp = 30; bp >= 0; bp--) begin
						c = r | (64'd1 << bp);
						if (q30_power(c, 3) <= fn) begin
							r = c;
						end
					end
					e = (r + (64'd1 << 14)) >> 15;
				end else begin
					// linear segment near black
					e = ((64'd9033 * num + 64'd160 * den) * 64'd32768 + 64'd580 * den)
						/ (64'd1160 * den);
				end
				f_lut[k][i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
			end
		end
	end

	function automatic lab_t predict_lab(input pixel_t p);
		bit [63:0] lin [3];
		bit [63:0] xyz, den, idx;
		longint    fv [3];
		longint    l, a, b;
		lab_t      res;
		lin[0] = 64'(linear_lut[p.red]);
		lin[1] = 64'(linear_lut[p.green]);
		lin[2] = 64'(linear_lut[p.blue]);
		for (int k = 0; k < 3; k++) begin
			xyz = lin[0] * 64'(MIX[k*3]) + lin[1] * 64'(MIX[k*3+1]) + lin[2] * 64'(MIX[k*3+2]);
			den = 64'(FULL_E5[k]) << 32;
			idx = (xyz * 64'(F_DEPTH - 1) * 64'd200000 + den) / (64'd2 * den);
			if (idx > 64'(F_DEPTH - 1)) begin
				idx = 64'(F_DEPTH - 1);
			end
			fv[k] = longint'(f_lut[k][idx]);
		end
		l = limit_to(round_to_q8(116 * fv[1] - 16 * 32768), 0, 25600);
		a = limit_to(round_to_q8(500 * (fv[0] - fv[1])), -32768, 32767);
		b = limit_to(round_to_q8(200 * (fv[1] - fv[2])), -32768, 32767);
		res.lightness   = 15'(l);
		res.green_red   = 16'(a);
		res.blue_yellow = 16'(b);
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] lab mismatch: %s", $realtime, msg);
		mismatch_n++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lab_entry_t want;
		if (!arst_n) begin
			lab_expected.delete();
			pending_n = 0;
		end else begin
			if (done) begin
				if (lab_expected.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending L=%0d a=%0d b=%0d",
						lab.lightness, lab.green_red, lab.blue_yellow));
				end else begin
					want = lab_expected.pop_front();
					compared_n++;
					if (lab.lightness !== want.lab.lightness)
						report_mismatch($sformatf("pixel %h lightness got %0d want %0d",
							want.src, lab.lightness, want.lab.lightness));
					if (lab.green_red !== want.lab.green_red)
						report_mismatch($sformatf("pixel %h green_red got %0d want %0d",
							want.src, lab.green_red, want.lab.green_red));
					if (lab.blue_yellow !== want.lab.blue_yellow)
						report_mismatch($sformatf("pixel %h blue_yellow got %0d want %0d",
							want.src, lab.blue_yellow, want.lab.blue_yellow));
				end
			end
			if (start && !busy) begin
				want.src = pixel;
				want.lab = predict_lab(pixel);
				lab_expected = {lab_expected, want};
			end
			pending_n = lab_expected.size();
		end
	end

endmodule

### sim/tb_top.sv
// testbench top for the srgb to cielab unit: clock, reset, pixel stimulus and verdict
module tb_top;
	import srgblab_pkg::*;

	// corner pixels: black, white, greys around the gamma knee, primaries and
	// secondaries for the extremes of a and b, near-black single channels
	localparam int N_CORNERS = 22;
	localparam bit [0:N_CORNERS-1][23:0] CORNERS = {
		24'h000000, 24'hFFFFFF, 24'h010101, 24'h0A0A0A, 24'h0B0B0B, 24'h808080,
		24'hFEFEFE, 24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h00FFFF,
		24'hFF00FF, 24'hFFFF00, 24'h0A0000, 24'h000B00, 24'h00000A, 24'hAA55AA,
		24'h55AA55, 24'h000001, 24'h0000FE, 24'h01FF01
	};
	localparam int N_RANDOM = 1800;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	pixel_t      pixel = '0;
	logic        busy;
	logic        done;
	lab_t        lab;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned compared;
	int unsigned sent = 0;

	always #5 clk = ~clk;

	srgb_to_cielab_pixel_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.pixel  (pixel),
		.done   (done),
		.lab    (lab)
	);

	// watches both channels, predicts every accepted pixel, compares every result
	lab_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.pixel      (pixel),
		.done       (done),
		.lab        (lab),
		.fail_count (fail_count),
		.pending    (pending),
		.compared   (compared)
	);

	// a byte from the ends of the range, or anywhere
	function automatic bit [7:0] edge_byte();
		case ($urandom_range(2))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// mostly uniform pixels, with greys, near-black pixels and saturated colors mixed in
	function automatic pixel_t random_pixel();
		int unsigned kind;
		bit [7:0]    g;
		pixel_t      p;
		kind = $urandom_range(99);
		p = pixel_t'(24'($urandom));
		if (kind < 15) begin
			// greys walk the whole lightness axis with a and b near zero
			g = 8'($urandom);
			p = pixel_t'({g, g, g});
		end else if (kind < 30) begin
			// the linear gamma segment and just past its knee, and the linear part of f(t)
			p.red   = 8'($urandom_range(14));
			p.green = 8'($urandom_range(14));
			p.blue  = 8'($urandom_range(14));
		end else if (kind < 45) begin
			// vivid colors push a and b toward their extremes
			p.red   = edge_byte();
			p.green = edge_byte();
			p.blue  = edge_byte();
		end
		return p;
	endfunction

	// one transaction; with gaps on, each cycle idles with a 37 percent chance
	task automatic send_pixel(input pixel_t p, input bit with_gaps);
		while (with_gaps && $urandom_range(99) < 37) begin
			start <= 1'b0;
			pixel <= pixel_t'(24'($urandom));
			@(posedge clk);
		end
		start <= 1'b1;
		pixel <= p;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		sent++;
	endtask

	// stop sending and wait for every predicted result to come back
	task automatic drain_pipeline();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		// reset held low from time zero, released on a clock edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners, with random gaps
		for (int n = 0; n < N_CORNERS; n++) begin
			send_pixel(pixel_t'(CORNERS[n]), 1'b1);
		end
		drain_pipeline();

		// random pixels; a long burst in the middle runs at full rate, and the
		// sender stops once more later on until the pipeline is empty
		for (int n = 0; n < N_RANDOM; n++) begin
			send_pixel(random_pixel(), !(n >= 700 && n < 1000));
			if (n == 1300) begin
				drain_pipeline();
			end
		end

		// last results, then a margin past the nine stage latency
		drain_pipeline();
		repeat (32) @(posedge clk);

		$display("summary: %0d pixels sent (%0d corner cases), %0d lab results compared",
			sent, N_CORNERS, compared);
		$display("summary: greys, primaries, gamma knee, near-black and vivid colors, %s",
			"with random gaps, a full-rate burst and pipeline drains");
		if (fail_count == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#5000000;
		$display("watchdog expired with %0d results outstanding", pending);
		$display("Mismatches found");
		$finish;
	end

endmodule
